[src/pftt_pkg.sv]
// shared types and constants for the periodic flag timer table
// no dependencies; imported by every module of the block
package pftt_pkg;

   localparam int NUM_TIMERS_DEFAULT = 8;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] KIND_TICK   = 2'd0;
   localparam logic [1:0] KIND_CREATE = 2'd1;
   localparam logic [1:0] KIND_ACK    = 2'd2;
   localparam logic [1:0] KIND_QUERY  = 2'd3;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_PENDING   = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [1:0] ST_FULL      = 2'd3;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] interval;
      logic [7:0]  timer_id;
      logic        id_ok;
   } cmd_type;

   typedef struct packed {
      logic [1:0] status;
      logic [2:0] assigned_id;
      logic [7:0] pending_mask;
   } rsp_type;

endpackage

[src/periodic_flag_timer_table.sv]
// Periodic flag timer table with queue-style request and result ports. Each
// request gives exactly one result, in order. Create, acknowledge and query
// are executed directly in the execution unit; a tick walks the created
// timers through the countdown table, one timer per cycle, with one read per
// cycle and a write only for timers that are not pending, and gives its
// result after the last one (without a walk when no timers are created).
// A two-entry command queue and a two-entry result queue sit on either side,
// so requests keep being taken while results wait to be popped; no clearing
// pass follows reset.
module periodic_flag_timer_table #(
   parameter int NUM_TIMERS = pftt_pkg::NUM_TIMERS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_kind,
   input  logic [15:0] req_interval,
   input  logic [7:0]  req_timer_id,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [1:0]  rsp_status,
   output logic [2:0]  rsp_assigned_id,
   output logic [7:0]  rsp_pending_mask
);
   import pftt_pkg::*;

   cmd_type                    cmd;
   logic                       cmd_valid;
   logic                       cmd_pop;
   rsp_type                    rsp_new;
   rsp_type                    rsp_out;
   logic [$bits(rsp_type)-1:0] rsp_flat;
   logic                       rsp_push;
   logic                       rsp_full;

   pftt_front #(
      .NUM_TIMERS(NUM_TIMERS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_kind    (req_kind),
      .req_interval(req_interval),
      .req_timer_id(req_timer_id),
      .cmd_pop     (cmd_pop),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd)
   );

   pftt_back #(
      .NUM_TIMERS(NUM_TIMERS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cmd_valid(cmd_valid),
      .cmd      (cmd),
      .cmd_pop  (cmd_pop),
      .rsp_room (!rsp_full),
      .rsp_push (rsp_push),
      .rsp      (rsp_new)
   );

   pftt_fifo #(
      .WIDTH($bits(rsp_type))
   ) u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (rsp_push),
      .push_data(rsp_new),
      .full     (rsp_full),
      .pop      (rsp_pop),
      .pop_data (rsp_flat),
      .empty    (rsp_empty)
   );

   assign rsp_out          = rsp_type'(rsp_flat);
   assign rsp_status       = rsp_out.status;
   assign rsp_assigned_id  = rsp_out.assigned_id;
   assign rsp_pending_mask = rsp_out.pending_mask;

`ifndef SYNTHESIS
   // a result transfer into the result queue never meets a full queue
   a_rsp_push_room: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full)
      else $error("result pushed into full queue");

   // commands are only taken from a nonempty command queue
   a_cmd_pop_valid: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid)
      else $error("command popped from empty queue");

   // a result is only produced while a command is taken or a tick walk runs
   a_rsp_with_cmd: assert property (@(posedge clock) disable iff (reset)
      (rsp_push && !cmd_pop) |-> $past(!cmd_pop || (cmd.kind == KIND_TICK)))
      else $error("result without command");

   // in the cycle after reset both queues are empty
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> (rsp_empty && !cmd_valid))
      else $error("queues not empty after reset");
`endif

endmodule

[src/pftt_fifo.sv]
// small first-in first-out queue of flat words
// depends on pftt_pkg for the depth and pointer widths
module pftt_fifo #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   import pftt_pkg::*;

   logic [WIDTH-1:0]  data_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign full     = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = data_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[src/pftt_front.sv]
// front end: takes request transfers, classifies them and queues commands
// depends on pftt_pkg and pftt_fifo
module pftt_front #(
   parameter int NUM_TIMERS = pftt_pkg::NUM_TIMERS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic [1:0]        req_kind,
   input  logic [15:0]       req_interval,
   input  logic [7:0]        req_timer_id,
   input  logic              cmd_pop,
   output logic              cmd_valid,
   output pftt_pkg::cmd_type cmd
);
   import pftt_pkg::*;

   cmd_type                cmd_new;
   logic [$bits(cmd_type)-1:0] cmd_flat;
   logic                   cmd_empty;

   always_comb begin
      cmd_new.kind     = req_kind;
      cmd_new.interval = req_interval;
      cmd_new.timer_id = req_timer_id;
      // id within the table size at all
      cmd_new.id_ok    = (req_timer_id < 8'(NUM_TIMERS));
   end

   pftt_fifo #(
      .WIDTH($bits(cmd_type))
   ) u_cmd_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (req_push),
      .push_data(cmd_new),
      .full     (req_full),
      .pop      (cmd_pop),
      .pop_data (cmd_flat),
      .empty    (cmd_empty)
   );

   assign cmd_valid = !cmd_empty;
   assign cmd       = cmd_type'(cmd_flat);

endmodule

[src/pftt_back.sv]
// back end: executes commands against the timer table and builds results
// depends on pftt_pkg; holds the countdown and reload memories
module pftt_back #(
   parameter int NUM_TIMERS = pftt_pkg::NUM_TIMERS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  pftt_pkg::cmd_type cmd,
   output logic              cmd_pop,
   input  logic              rsp_room,
   output logic              rsp_push,
   output pftt_pkg::rsp_type rsp
);
   import pftt_pkg::*;

   localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int UW = $clog2(NUM_TIMERS + 1);
   localparam int PW = (NUM_TIMERS > 8) ? NUM_TIMERS : 8;
   localparam int AW = (UW > 3) ? UW : 3;

   localparam logic S_IDLE = 1'b0;
   localparam logic S_WALK = 1'b1;

   logic [15:0]           cnt_mem [NUM_TIMERS];
   logic [15:0]           rel_mem [NUM_TIMERS];
   logic [15:0]           cnt_rd_ff, rel_rd_ff;

   logic                  state_ff, state_in;
   logic [IW-1:0]         idx_ff, idx_in;
   logic [UW-1:0]         in_use_ff, in_use_in;
   logic [NUM_TIMERS-1:0] pend_ff, pend_in;

   logic [IW-1:0]         rd_addr;
   logic                  cnt_wr_en, rel_wr_en;
   logic [IW-1:0]         wr_addr;
   logic [15:0]           cnt_wr_data;
   logic [15:0]           rel_wr_data;

   logic                  found;
   logic [PW-1:0]         pend_pad;
   logic [AW-1:0]         slot_pad;

   assign found    = cmd.id_ok && (cmd.timer_id < 8'(in_use_ff));
   assign pend_pad = PW'(pend_in);
   assign slot_pad = AW'(in_use_ff);

   always_comb begin
      state_in        = state_ff;
      idx_in          = idx_ff;
      in_use_in       = in_use_ff;
      pend_in         = pend_ff;
      rd_addr         = idx_ff;
      cnt_wr_en       = 1'b0;
      rel_wr_en       = 1'b0;
      wr_addr         = idx_ff;
      cnt_wr_data     = cmd.interval;
      rel_wr_data     = cmd.interval;
      cmd_pop         = 1'b0;
      rsp_push        = 1'b0;
      rsp.status      = ST_OK;
      rsp.assigned_id = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid && rsp_room) begin
               cmd_pop = 1'b1;
               unique case (cmd.kind)
                  KIND_TICK: begin
                     if (in_use_ff == '0) begin
                        rsp_push = 1'b1;
                     end else begin
                        state_in = S_WALK;
                        idx_in   = '0;
                        rd_addr  = '0;
                     end
                  end
                  KIND_CREATE: begin
                     rsp_push = 1'b1;
                     if (in_use_ff != UW'(NUM_TIMERS)) begin
                        cnt_wr_en        = 1'b1;
                        rel_wr_en        = 1'b1;
                        wr_addr          = in_use_ff[IW-1:0];
                        pend_in[wr_addr] = 1'b0;
                        in_use_in        = in_use_ff + UW'(1);
                        rsp.assigned_id  = slot_pad[2:0];
                     end else begin
                        rsp.status = ST_FULL;
                     end
                  end
                  KIND_ACK: begin
                     rsp_push = 1'b1;
                     if (found) begin
                        pend_in[cmd.timer_id[IW-1:0]] = 1'b0;
                     end else begin
                        rsp.status = ST_NOT_FOUND;
                     end
                  end
                  KIND_QUERY: begin
                     rsp_push = 1'b1;
                     if (!found) begin
                        rsp.status = ST_NOT_FOUND;
                     end else if (pend_ff[cmd.timer_id[IW-1:0]]) begin
                        rsp.status = ST_PENDING;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_WALK: begin
            // one timer per cycle, read data for idx_ff is in cnt_rd_ff/rel_rd_ff
            if (!pend_ff[idx_ff]) begin
               cnt_wr_en = 1'b1;
               if (cnt_rd_ff != 16'd0) begin
                  cnt_wr_data = cnt_rd_ff - 16'd1;
               end else begin
                  cnt_wr_data     = rel_rd_ff;
                  pend_in[idx_ff] = 1'b1;
               end
            end
            if ((UW'(idx_ff) + UW'(1)) == in_use_ff) begin
               rsp_push = 1'b1;
               state_in = S_IDLE;
            end else begin
               idx_in  = idx_ff + IW'(1);
               rd_addr = idx_ff + IW'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      rsp.pending_mask = pend_pad[7:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         idx_ff    <= '0;
         in_use_ff <= '0;
         pend_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         idx_ff    <= idx_in;
         in_use_ff <= in_use_in;
         pend_ff   <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cnt_wr_en) begin
         cnt_mem[wr_addr] <= cnt_wr_data;
      end
      cnt_rd_ff <= cnt_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (rel_wr_en) begin
         rel_mem[wr_addr] <= rel_wr_data;
      end
      rel_rd_ff <= rel_mem[rd_addr];
   end

endmodule
